// ----- hdl/tle_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tle_pkg: shared types and constants of the terminal line editor
// Byte codes, result kinds, controller states and the command and status
// words between controller and datapath.
// ----------------------------------------------------------------------------
package tle_pkg;

	localparam int LINE_MAX = 63;
	localparam int CNT_W    = 6;
	localparam int CHAR_W   = 7;

	localparam logic [7:0] BYTE_BS    = 8'h08;
	localparam logic [7:0] BYTE_CR    = 8'h0D;
	localparam logic [7:0] BYTE_ESC   = 8'h1B;
	localparam logic [7:0] BYTE_SP    = 8'h20;
	localparam logic [7:0] BYTE_TILDE = 8'h7E;
	localparam logic [7:0] BYTE_DEL   = 8'h7F;
	localparam logic [7:0] BYTE_LBRK  = 8'h5B;
	localparam logic [7:0] BYTE_A     = 8'h41;

	localparam logic [CNT_W-1:0] MAX_LEN_RESET = CNT_W'(LINE_MAX);

	typedef enum logic [1:0] {
		KIND_ECHO   = 2'd0,
		KIND_CHAR   = 2'd1,
		KIND_END    = 2'd2,
		KIND_RECALL = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ESC_IDLE    = 2'd0,
		ESC_SEEN    = 2'd1,
		ESC_BRACKET = 2'd2
	} esc_t;

	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_ERASE,
		ACT_RECALL,
		ACT_PRINT,
		ACT_CR
	} act_t;

	typedef enum logic [2:0] {
		SEL_ZERO,
		SEL_BS,
		SEL_SP,
		SEL_RX,
		SEL_MEM
	} sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ERASE0,
		ST_ERASE1,
		ST_ERASE2,
		ST_RECALL,
		ST_ECHO,
		ST_READ,
		ST_CHAR,
		ST_END
	} state_t;

	typedef struct packed {
		logic  accept;
		logic  rd_start;
		logic  rd_en;
		logic  rd_next;
		logic  emit;
		kind_t emit_kind;
		sel_t  emit_sel;
		logic  emit_len;
		logic  emit_last;
		logic  clear_count;
	} cmd_t;

	typedef struct packed {
		act_t act;
		logic count_zero;
		logic rd_last;
		logic out_free;
	} status_t;

endpackage

// ----- hdl/tle_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tle_ctrl: sequencing controller
// Accepts one byte at a time and steps through the results it causes.
// ----------------------------------------------------------------------------
module tle_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  tle_pkg::status_t status,
	output tle_pkg::cmd_t    cmd
);

	tle_pkg::state_t state_q, state_d;
	logic            recall_q, recall_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= tle_pkg::ST_IDLE;
			recall_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			recall_q <= recall_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		recall_d      = recall_q;
		in_stall      = 1'b1;
		cmd           = '0;
		cmd.emit_kind = tle_pkg::KIND_ECHO;
		cmd.emit_sel  = tle_pkg::SEL_ZERO;
		unique case (state_q)
			tle_pkg::ST_IDLE: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
				if (in_valid) begin
					unique case (status.act)
						tle_pkg::ACT_ERASE: begin
							state_d  = tle_pkg::ST_ERASE0;
							recall_d = 1'b0;
						end
						tle_pkg::ACT_RECALL: begin
							state_d  = tle_pkg::ST_ERASE0;
							recall_d = 1'b1;
						end
						tle_pkg::ACT_PRINT: state_d = tle_pkg::ST_ECHO;
						tle_pkg::ACT_CR: begin
							cmd.rd_start = 1'b1;
							state_d = status.count_zero ? tle_pkg::ST_END : tle_pkg::ST_READ;
						end
						default: state_d = tle_pkg::ST_IDLE;
					endcase
				end
			end
			tle_pkg::ST_ERASE0: begin
				cmd.emit_sel = tle_pkg::SEL_BS;
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = tle_pkg::ST_ERASE1;
				end
			end
			tle_pkg::ST_ERASE1: begin
				cmd.emit_sel = tle_pkg::SEL_SP;
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = tle_pkg::ST_ERASE2;
				end
			end
			tle_pkg::ST_ERASE2: begin
				cmd.emit_sel  = tle_pkg::SEL_BS;
				cmd.emit_last = !recall_q;
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = recall_q ? tle_pkg::ST_RECALL : tle_pkg::ST_IDLE;
				end
			end
			tle_pkg::ST_RECALL: begin
				cmd.emit_kind = tle_pkg::KIND_RECALL;
				cmd.emit_last = 1'b1;
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = tle_pkg::ST_IDLE;
				end
			end
			tle_pkg::ST_ECHO: begin
				cmd.emit_sel  = tle_pkg::SEL_RX;
				cmd.emit_last = 1'b1;
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = tle_pkg::ST_IDLE;
				end
			end
			tle_pkg::ST_READ: begin
				cmd.rd_en = 1'b1;
				state_d   = tle_pkg::ST_CHAR;
			end
			tle_pkg::ST_CHAR: begin
				cmd.emit_kind = tle_pkg::KIND_CHAR;
				cmd.emit_sel  = tle_pkg::SEL_MEM;
				if (status.out_free) begin
					cmd.emit    = 1'b1;
					cmd.rd_next = 1'b1;
					state_d = status.rd_last ? tle_pkg::ST_END : tle_pkg::ST_READ;
				end
			end
			tle_pkg::ST_END: begin
				cmd.emit_kind = tle_pkg::KIND_END;
				cmd.emit_len  = 1'b1;
				cmd.emit_last = 1'b1;
				if (status.out_free) begin
					cmd.emit        = 1'b1;
					cmd.clear_count = 1'b1;
					state_d         = tle_pkg::ST_IDLE;
				end
			end
			default: state_d = tle_pkg::ST_IDLE;
		endcase
	end

endmodule

// ----- hdl/tle_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tle_datapath: byte decode, line store and output register
// Holds the escape phase, character count, length limit and line memory.
// ----------------------------------------------------------------------------
module tle_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [7:0]                        rx_byte,
	input  logic                              cfg_valid,
	input  logic [tle_pkg::CNT_W-1:0]         cfg_data,
	input  tle_pkg::cmd_t                     cmd,
	output tle_pkg::status_t                  status,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [1:0]                        out_kind,
	output logic [7:0]                        out_byte,
	output logic [tle_pkg::CNT_W-1:0]         line_length,
	output logic                              last
);

	logic [tle_pkg::CHAR_W-1:0] mem [tle_pkg::LINE_MAX];
	logic [tle_pkg::CHAR_W-1:0] rd_data_q;
	logic [tle_pkg::CNT_W-1:0]  count_q, max_len_q, idx_q;
	logic [7:0]                 rx_q;
	tle_pkg::esc_t              esc_q, esc_d;
	tle_pkg::act_t              act;
	logic                       out_valid_q, last_q;
	tle_pkg::kind_t             kind_q;
	logic [7:0]                 byte_q, byte_d;
	logic [tle_pkg::CNT_W-1:0]  len_q;

	always_comb begin
		act   = tle_pkg::ACT_NONE;
		esc_d = esc_q;
		unique case (esc_q)
			tle_pkg::ESC_IDLE: begin
				if (rx_byte == tle_pkg::BYTE_ESC) esc_d = tle_pkg::ESC_SEEN;
				else if (rx_byte == tle_pkg::BYTE_BS || rx_byte == tle_pkg::BYTE_DEL)
					act = tle_pkg::ACT_ERASE;
				else if (rx_byte == tle_pkg::BYTE_CR) act = tle_pkg::ACT_CR;
				else if (rx_byte >= tle_pkg::BYTE_SP && rx_byte <= tle_pkg::BYTE_TILDE)
					act = tle_pkg::ACT_PRINT;
			end
			tle_pkg::ESC_SEEN: begin
				esc_d = (rx_byte == tle_pkg::BYTE_LBRK) ? tle_pkg::ESC_BRACKET
				                                         : tle_pkg::ESC_IDLE;
			end
			tle_pkg::ESC_BRACKET: begin
				esc_d = tle_pkg::ESC_IDLE;
				if (rx_byte == tle_pkg::BYTE_A) act = tle_pkg::ACT_RECALL;
			end
			default: esc_d = tle_pkg::ESC_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q     <= tle_pkg::ESC_IDLE;
			count_q   <= '0;
			max_len_q <= tle_pkg::MAX_LEN_RESET;
		end else begin
			if (cfg_valid) max_len_q <= cfg_data;
			if (cmd.accept) begin
				esc_q <= esc_d;
				case (act)
					tle_pkg::ACT_PRINT:
						if (count_q < max_len_q) count_q <= count_q + 1'b1;
					tle_pkg::ACT_ERASE:
						if (count_q != '0) count_q <= count_q - 1'b1;
					tle_pkg::ACT_RECALL: count_q <= '0;
					default: count_q <= count_q;
				endcase
			end else if (cmd.clear_count) begin
				count_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) rx_q <= rx_byte;
		if (cmd.accept && act == tle_pkg::ACT_PRINT && count_q < max_len_q)
			mem[count_q] <= rx_byte[tle_pkg::CHAR_W-1:0];
		if (cmd.rd_en) rd_data_q <= mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) idx_q <= '0;
		else if (cmd.rd_start) idx_q <= '0;
		else if (cmd.rd_next) idx_q <= idx_q + 1'b1;
	end

	always_comb begin
		unique case (cmd.emit_sel)
			tle_pkg::SEL_BS:  byte_d = tle_pkg::BYTE_BS;
			tle_pkg::SEL_SP:  byte_d = tle_pkg::BYTE_SP;
			tle_pkg::SEL_RX:  byte_d = rx_q;
			tle_pkg::SEL_MEM: byte_d = {1'b0, rd_data_q};
			default:          byte_d = 8'h00;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.emit) out_valid_q <= 1'b1;
		else if (!out_stall) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			kind_q <= cmd.emit_kind;
			byte_q <= byte_d;
			len_q  <= cmd.emit_len ? count_q : '0;
			last_q <= cmd.emit_last;
		end
	end

	assign status.act        = act;
	assign status.count_zero = (count_q == '0);
	assign status.rd_last    = ({1'b0, idx_q} + 1'b1) == {1'b0, count_q};
	assign status.out_free   = !out_valid_q || !out_stall;

	assign out_valid   = out_valid_q;
	assign out_kind    = kind_q;
	assign out_byte    = byte_q;
	assign line_length = len_q;
	assign last        = last_q;

endmodule

// ----- hdl/terminal_line_editor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// terminal_line_editor: line editor with echo for received terminal bytes
// Builds an input line, echoes typing, handles erase, recall and line end.
// ----------------------------------------------------------------------------
//  channel | handshake            | word
//  --------+----------------------+-----------------------------------------
//  in      | in_valid / in_stall  | rx_byte
//  out     | out_valid / out_stall| out_kind, out_byte, line_length, last
//  cfg     | cfg_valid / cfg_ready| cfg_data (max_length)
//
//  A byte is taken only while the controller is idle; each result then has
//  its own controller state, and each stored character on line end has a
//  read state and an emit state (registered line memory read).
//  Reset clears the escape phase, character count and output valid; the line
//  memory is not cleared. A stalled output holds its word; the next byte is
//  still taken while the last result of the previous one waits.
// ----------------------------------------------------------------------------
module terminal_line_editor (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [7:0]                rx_byte,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [1:0]                out_kind,
	output logic [7:0]                out_byte,
	output logic [tle_pkg::CNT_W-1:0] line_length,
	output logic                      last,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [tle_pkg::CNT_W-1:0] cfg_data
);

	tle_pkg::cmd_t    cmd;
	tle_pkg::status_t status;

	assign cfg_ready = 1'b1;

	tle_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	tle_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.rx_byte     (rx_byte),
		.cfg_valid   (cfg_valid),
		.cfg_data    (cfg_data),
		.cmd         (cmd),
		.status      (status),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_kind    (out_kind),
		.out_byte    (out_byte),
		.line_length (line_length),
		.last        (last)
	);

	a_char_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_valid && last && out_kind == tle_pkg::KIND_CHAR))
		else $error("line character marked as final result");

	a_zero_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_kind == tle_pkg::KIND_END || out_kind == tle_pkg::KIND_RECALL)
		|-> out_byte == 8'h00)
		else $error("nonzero byte on line end or recall");

	a_len_only_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind != tle_pkg::KIND_END |-> line_length == '0)
		else $error("line length outside line end");

	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_kind == tle_pkg::KIND_END || out_kind == tle_pkg::KIND_RECALL)
		|-> last)
		else $error("line end or recall not final");

endmodule
